// File: hdl/rlim_pkg.sv
// ----------------------------------------------------------------------------
// rlim_pkg
// Shared types and constants of the fixed-window rate limiter.
// ----------------------------------------------------------------------------
package rlim_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int MS_PER_SEC        = 1000;

  // threshold (window + 1) * 1000 fits in 27 bits
  localparam int THR_W = 27;

  localparam int APB_ADDR_W = 3;
  localparam logic REG_IDX_ENABLE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_TIME,
    ST_EVAL,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    STAT_NEW      = 3'd0,
    STAT_WIN_RST  = 3'd1,
    STAT_COUNTED  = 3'd2,
    STAT_DENIED   = 3'd3,
    STAT_FULL     = 3'd4,
    STAT_DISABLED = 3'd5,
    STAT_CLEARED  = 3'd6
  } status_e;

  typedef enum logic {
    KIND_CHECK = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_e;

  typedef struct packed {
    logic [15:0] window;
    logic [47:0] start_ms;
    logic [15:0] count;
    logic [15:0] action;
    logic [31:0] user;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] user_code;
    logic [15:0] action_code;
    logic [47:0] now_ms;
    logic [15:0] window_secs;
    logic [15:0] limit;
  } req_t;

  typedef struct packed {
    logic        allowed;
    status_e     status;
    logic [15:0] count_after;
  } res_t;

endpackage

// File: hdl/rlim_ram.sv
// ----------------------------------------------------------------------------
// rlim_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rlim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rlim_cfg.sv
// ----------------------------------------------------------------------------
// rlim_cfg
// APB register block holding the enable bit.
// ----------------------------------------------------------------------------
module rlim_cfg
  import rlim_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic                  enable_o
);

  logic enable_q, enable_d;
  logic wr_en;

  // word index sits in paddr[2], byte offset ignored
  assign wr_en = psel && penable && pwrite && (paddr[2] == REG_IDX_ENABLE);

  always_comb begin
    enable_d = enable_q;
    if (wr_en) begin
      enable_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else begin
      enable_q <= enable_d;
    end
  end

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_IDX_ENABLE) ? {31'b0, enable_q} : 32'b0;
  assign enable_o = enable_q;

endmodule

// File: hdl/rlim_seq.sv
// ----------------------------------------------------------------------------
// rlim_seq
// Sequencer walking the counter table with one shared key comparator,
// then judging the window and the count of the matching entry.
// ----------------------------------------------------------------------------
module rlim_seq
  import rlim_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic enable_i,
  input  logic req_valid_i,
  input  req_t req_i,
  output logic idle_o,
  output logic done_o,
  input  logic out_free_i,
  output res_t res_o
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int EW    = $bits(entry_t);

  state_e state_q, state_d;

  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  req_t             req_q, req_d;
  entry_t           hit_q, hit_d;
  logic [47:0]      diff_q, diff_d;
  logic [THR_W-1:0] thr_q, thr_d;
  res_t             res_q, res_d;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata;
  logic [EW-1:0]    ram_rdata;
  entry_t           rd_entry;

  logic             key_hit, scan_more, scan_end, table_full, win_over;
  logic [16:0]      win_p1;

  assign rd_entry   = entry_t'(ram_rdata);
  // shared key comparator, fed one table entry per cycle
  assign key_hit    = rd_vld_q && (rd_entry.user == req_q.user_code)
                      && (rd_entry.action == req_q.action_code);
  assign scan_more  = idx_q < used_q;
  assign scan_end   = !rd_vld_q && !scan_more;
  assign table_full = used_q == CNT_W'(TABLE_ENTRIES);
  assign win_over   = diff_q >= 48'(thr_q);
  assign win_p1     = {1'b0, hit_q.window} + 17'd1;

  rlim_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_START;
      end
      ST_START: begin
        if (!enable_i || req_q.kind == KIND_CLEAR) state_d = ST_FIN;
        else state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (key_hit) state_d = ST_TIME;
        else if (scan_end) state_d = ST_FIN;
      end
      ST_TIME: state_d = ST_EVAL;
      ST_EVAL: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and table control
  always_comb begin
    used_d    = used_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    hit_idx_d = hit_idx_q;
    req_d     = req_q;
    hit_d     = hit_q;
    diff_d    = diff_q;
    thr_d     = thr_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = hit_idx_q;
    ram_raddr = idx_q[IDX_W-1:0];
    ram_wdata = hit_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_d = req_i;
          idx_d = '0;
        end
      end
      ST_START: begin
        if (!enable_i) begin
          res_d = '{allowed: 1'b1, status: STAT_DISABLED, count_after: 16'd0};
        end else if (req_q.kind == KIND_CLEAR) begin
          used_d = '0;
          res_d  = '{allowed: 1'b0, status: STAT_CLEARED, count_after: 16'd0};
        end
      end
      ST_SCAN: begin
        ram_re   = scan_more && !key_hit;
        rd_vld_d = ram_re;
        if (ram_re) begin
          idx_d    = idx_q + CNT_W'(1);
          rd_idx_d = idx_q[IDX_W-1:0];
        end
        if (key_hit) begin
          hit_d     = rd_entry;
          hit_idx_d = rd_idx_q;
        end else if (scan_end) begin
          if (table_full) begin
            res_d = '{allowed: 1'b1, status: STAT_FULL, count_after: 16'd0};
          end else begin
            ram_we    = 1'b1;
            ram_waddr = used_q[IDX_W-1:0];
            ram_wdata = '{window: req_q.window_secs, start_ms: req_q.now_ms,
                          count: 16'd1, action: req_q.action_code,
                          user: req_q.user_code};
            used_d    = used_q + CNT_W'(1);
            res_d     = '{allowed: 1'b1, status: STAT_NEW, count_after: 16'd1};
          end
        end
      end
      ST_TIME: begin
        // elapsed seconds exceed window when diff >= (window + 1) * 1000
        diff_d = req_q.now_ms - hit_q.start_ms;
        thr_d  = THR_W'(27'(win_p1) * 27'(MS_PER_SEC));
      end
      ST_EVAL: begin
        if (win_over) begin
          ram_we             = 1'b1;
          ram_wdata.count    = 16'd1;
          ram_wdata.start_ms = req_q.now_ms;
          res_d = '{allowed: 1'b1, status: STAT_WIN_RST, count_after: 16'd1};
        end else if (hit_q.count >= req_q.limit) begin
          res_d = '{allowed: 1'b0, status: STAT_DENIED, count_after: hit_q.count};
        end else begin
          ram_we          = 1'b1;
          ram_wdata.count = hit_q.count + 16'd1;
          res_d = '{allowed: 1'b1, status: STAT_COUNTED,
                    count_after: hit_q.count + 16'd1};
        end
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      used_q   <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    hit_idx_q <= hit_idx_d;
    req_q     <= req_d;
    hit_q     <= hit_d;
    diff_q    <= diff_d;
    thr_q     <= thr_d;
    res_q     <= res_d;
  end

  assign idle_o = state_q == ST_IDLE;
  assign done_o = state_q == ST_FIN;
  assign res_o  = res_q;

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_SCAN || state_q == ST_EVAL))
    else $error("table written outside scan or evaluate");

  a_used_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(used_q) |-> ($past(state_q) == ST_START || $past(state_q) == ST_SCAN))
    else $error("fill count changed outside start or scan");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (CNT_W'(rd_idx_q) < used_q))
    else $error("read beat beyond filled entries");

  a_rd_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == ST_SCAN)
    else $error("read beat not issued by scan");

endmodule

// File: hdl/fixed_window_rate_limiter.sv
// ----------------------------------------------------------------------------
// fixed_window_rate_limiter
// Per user and action fixed-window request counters with an APB enable bit.
// ----------------------------------------------------------------------------
// flow: disabled or clear beats go from accept straight to the result; a check
//   walks the n filled entries at one entry per cycle, then times and judges
//   the matching entry, or adds a new one
// throughput: one beat at a time; the next beat is taken once the result sits
//   in the output register
// reset: asynchronous, active low; clears the fill count and the enable bit
module fixed_window_rate_limiter
  import rlim_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // user_code[31:0], action_code[47:32], now_ms[95:48], window_secs[111:96],
  // limit[127:112]
  input  logic [127:0]          s_axis_tdata,
  // kind[0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // allowed[0], status[3:1], count_after[19:4], zero[23:20]
  output logic [23:0]           m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic enable;
  logic seq_idle, seq_done, out_free;
  req_t req;
  res_t seq_res;
  logic out_vld_q, out_vld_d;
  res_t out_q;

  assign req = '{kind: kind_e'(s_axis_tuser),
                 user_code: s_axis_tdata[31:0],
                 action_code: s_axis_tdata[47:32],
                 now_ms: s_axis_tdata[95:48],
                 window_secs: s_axis_tdata[111:96],
                 limit: s_axis_tdata[127:112]};

  rlim_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .enable_o (enable)
  );

  rlim_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (enable),
    .req_valid_i (s_axis_tvalid && seq_idle),
    .req_i       (req),
    .idle_o      (seq_idle),
    .done_o      (seq_done),
    .out_free_i  (out_free),
    .res_o       (seq_res)
  );

  // output register parts the sequencer from the result consumer
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_free) begin
      out_vld_d = seq_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && seq_done) begin
      out_q <= seq_res;
    end
  end

  assign s_axis_tready = seq_idle;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_q.count_after, 3'(out_q.status), out_q.allowed};

endmodule

// File: sim/fixed_window_rate_limiter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_window_rate_limiter_tb
// Self-checking bench for the rate limiter. Requests go in on the slave stream
// and the enable bit is set over APB. A shadow copy of the counter table
// predicts each decision beat that a directed row does not type out. Directed rows come first, then random
// traffic over a small key pool, a table-fill phase and disabled phases.
// ----------------------------------------------------------------------------
module fixed_window_rate_limiter_tb;
  import rlim_pkg::*;

  localparam int N_ENTRIES   = TABLE_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYC  = 80;
  localparam int HOLD_CYC    = 300;
  localparam int POOL_KEYS   = 8;
  localparam logic [APB_ADDR_W-1:0] ADDR_ENABLE = {REG_IDX_ENABLE, 2'b00};

  typedef struct packed {
    logic   en;
    req_t   r;
    logic   typed;
    res_t   exp;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [127:0]          s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [23:0]           m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // shadow of the counter table and the enable bit
  logic [31:0] tbl_user  [N_ENTRIES];
  logic [15:0] tbl_act   [N_ENTRIES];
  logic [15:0] tbl_cnt   [N_ENTRIES];
  logic [47:0] tbl_start [N_ENTRIES];
  logic [15:0] tbl_win   [N_ENTRIES];
  int          tbl_used;
  logic        en_shadow;

  res_t        decision_q [$];
  dir_row_t    dir_rows   [$];
  logic [31:0] pool_user  [POOL_KEYS];
  logic [15:0] pool_act   [POOL_KEYS];
  logic [47:0] now_ms_cur;
  int          err_cnt;
  int          cycle_cnt;
  int          hold_req;
  bit          idle_en;

  fixed_window_rate_limiter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic res_t limiter_decide(req_t r);
    res_t        d;
    logic [47:0] since;
    logic [47:0] secs;
    int          hit;
    int          i;
    d.allowed     = 1'b1;
    d.status      = STAT_DISABLED;
    d.count_after = 16'd0;
    if (!en_shadow) return d;
    if (r.kind == KIND_CLEAR) begin
      tbl_used  = 0;
      d.allowed = 1'b0;
      d.status  = STAT_CLEARED;
      return d;
    end
    hit = -1;
    for (i = 0; i < tbl_used; i++) begin
      if (hit < 0 && tbl_user[i] == r.user_code && tbl_act[i] == r.action_code) hit = i;
    end
    if (hit >= 0) begin
      since = r.now_ms - tbl_start[hit];
      secs  = since / 48'd1000;
      if (secs > {32'd0, tbl_win[hit]}) begin
        tbl_cnt[hit]   = 16'd1;
        tbl_start[hit] = r.now_ms;
        d.status       = STAT_WIN_RST;
        d.count_after  = 16'd1;
      end else if (tbl_cnt[hit] >= r.limit) begin
        d.allowed     = 1'b0;
        d.status      = STAT_DENIED;
        d.count_after = tbl_cnt[hit];
      end else begin
        tbl_cnt[hit]  = tbl_cnt[hit] + 16'd1;
        d.status      = STAT_COUNTED;
        d.count_after = tbl_cnt[hit];
      end
    end else if (tbl_used < N_ENTRIES) begin
      tbl_user[tbl_used]  = r.user_code;
      tbl_act[tbl_used]   = r.action_code;
      tbl_cnt[tbl_used]   = 16'd1;
      tbl_start[tbl_used] = r.now_ms;
      tbl_win[tbl_used]   = r.window_secs;
      tbl_used++;
      d.status      = STAT_NEW;
      d.count_after = 16'd1;
    end else begin
      d.status = STAT_FULL;
    end
    return d;
  endfunction

  // mostly pool keys with small windows and limits so that hits, resets and
  // denials all turn up; fill mode brings fresh keys to run the table full
  function automatic req_t random_req(bit fill);
    req_t r;
    int   k;
    k             = $urandom_range(0, POOL_KEYS - 1);
    r.kind        = KIND_CHECK;
    r.user_code   = pool_user[k];
    r.action_code = pool_act[k];
    if (fill && $urandom_range(0, 9) < 7) begin
      r.user_code   = $urandom;
      r.action_code = 16'($urandom);
    end else if (!fill && $urandom_range(0, 99) < 3) begin
      r.kind = KIND_CLEAR;
    end else if (!fill && $urandom_range(0, 99) < 4) begin
      r.user_code   = $urandom;
      r.action_code = 16'($urandom);
    end
    if ($urandom_range(0, 99) < 3) now_ms_cur = 48'({$urandom, $urandom});
    else now_ms_cur = now_ms_cur + 48'($urandom_range(0, 2500));
    r.now_ms      = now_ms_cur;
    r.window_secs = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    r.limit       = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    return r;
  endfunction

  task automatic add_row(input logic en, input kind_e kind, input logic [31:0] user,
                         input logic [15:0] act, input logic [47:0] now,
                         input logic [15:0] win, input logic [15:0] lim,
                         input logic typed, input logic allowed,
                         input status_e status, input logic [15:0] cnt);
    dir_row_t row;
    row.en              = en;
    row.r.kind          = kind;
    row.r.user_code     = user;
    row.r.action_code   = act;
    row.r.now_ms        = now;
    row.r.window_secs   = win;
    row.r.limit         = lim;
    row.typed           = typed;
    row.exp.allowed     = allowed;
    row.exp.status      = status;
    row.exp.count_after = cnt;
    dir_rows.push_back(row);
  endtask

  // valid is left high after acceptance; the next call or drain decides
  task automatic send_req(input req_t r, input logic typed, input res_t typed_res);
    res_t d;
    d = limiter_decide(r);
    if (typed) d = typed_res;
    while (idle_en && $urandom_range(0, 99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {r.limit, r.window_secs, r.now_ms, r.action_code, r.user_code};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decision_q.push_back(d);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (decision_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", msg);
  endtask

  // write the enable bit, then read it back
  task automatic set_enable(input logic v);
    logic [31:0] rd;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_ENABLE;
    pwdata  <= {31'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    en_shadow = v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[0] !== v) note_mismatch($sformatf("enable read back exp %0d got %0d", v, rd[0]));
  endtask

  // result side: check each beat and drive tready, with one long hold-off
  initial begin : result_sink
    int   hold_left;
    int   hold_seen;
    res_t e;
    hold_left = 0;
    hold_seen = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (decision_q.size() == 0) begin
          note_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
        end else begin
          e = decision_q.pop_front();
          if (m_axis_tdata[0] !== e.allowed || m_axis_tdata[3:1] !== e.status ||
              m_axis_tdata[19:4] !== e.count_after)
            note_mismatch($sformatf("exp allowed=%0d status=%0d count=%0d, got %0d %0d %0d",
                                    e.allowed, e.status, e.count_after, m_axis_tdata[0],
                                    m_axis_tdata[3:1], m_axis_tdata[19:4]));
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(idle_en && $urandom_range(0, 99) < 16);
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    res_t     none;
    dir_row_t row;
    int       i;
    int       ph;
    int       n_items;
    bit       fill;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    none          = '0;
    err_cnt       = 0;
    hold_req      = 0;
    idle_en       = 1'b1;
    tbl_used      = 0;
    en_shadow     = 1'b0;
    now_ms_cur    = '0;
    pool_user[0]  = 32'd0;
    pool_act[0]   = 16'd0;
    pool_user[1]  = 32'hFFFF_FFFF;
    pool_act[1]   = 16'hFFFF;
    for (i = 2; i < POOL_KEYS; i++) begin
      pool_user[i] = $urandom;
      pool_act[i]  = 16'($urandom);
    end
    // same user as another key but a different action, and the reverse
    pool_user[2] = pool_user[3];
    pool_act[4]  = pool_act[5];

    // en kind user action now window limit | typed allowed status count
    add_row(0, KIND_CHECK, 32'd1, 16'd1, 48'd0, 16'd0, 16'd0, 1, 1, STAT_DISABLED, 16'd0);
    add_row(0, KIND_CLEAR, 32'd0, 16'd0, 48'd0, 16'd0, 16'd0, 1, 1, STAT_DISABLED, 16'd0);
    add_row(1, KIND_CHECK, 32'd0, 16'd0, 48'd0, 16'd0, 16'd0, 1, 1, STAT_NEW, 16'd1);
    // zero limit inside the window
    add_row(1, KIND_CHECK, 32'd0, 16'd0, 48'd0, 16'd0, 16'd0, 1, 0, STAT_DENIED, 16'd1);
    // window reset keeps the stored window of zero
    add_row(1, KIND_CHECK, 32'd0, 16'd0, 48'd1000, 16'd5, 16'd0, 1, 1, STAT_WIN_RST, 16'd1);
    add_row(1, KIND_CHECK, 32'd0, 16'd0, 48'd1999, 16'd7, 16'd3, 0, 0, STAT_NEW, 16'd0);
    add_row(1, KIND_CHECK, 32'd0, 16'd0, 48'd2000, 16'd0, 16'd3, 0, 0, STAT_NEW, 16'd0);
    add_row(1, KIND_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF,
            1, 1, STAT_NEW, 16'd1);
    // time wraps past the top of the 48 bit range
    add_row(1, KIND_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 48'd0, 16'd0, 16'hFFFF,
            0, 0, STAT_NEW, 16'd0);
    add_row(1, KIND_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 48'h1000, 16'd0, 16'd0,
            0, 0, STAT_NEW, 16'd0);
    add_row(1, KIND_CHECK, 32'h5555_5555, 16'hAAAA, 48'h8000_0000_0000, 16'd2, 16'd2,
            0, 0, STAT_NEW, 16'd0);
    add_row(1, KIND_CHECK, 32'h5555_5555, 16'hAAAA, 48'h8000_0000_05DC, 16'd9, 16'd2,
            0, 0, STAT_NEW, 16'd0);
    add_row(1, KIND_CHECK, 32'h5555_5555, 16'hAAAA, 48'h8000_0000_09C4, 16'd9, 16'd2,
            0, 0, STAT_NEW, 16'd0);
    add_row(1, KIND_CHECK, 32'h5555_5555, 16'hAAAA, 48'h8000_0000_0BB8, 16'd9, 16'd2,
            0, 0, STAT_NEW, 16'd0);
    // time going backwards
    add_row(1, KIND_CHECK, 32'h5555_5555, 16'hAAAA, 48'd0, 16'd9, 16'd2,
            0, 0, STAT_NEW, 16'd0);
    add_row(1, KIND_CHECK, 32'hAAAA_AAAA, 16'h5555, 48'h7FFF_FFFF_FFFF, 16'd1, 16'd1,
            0, 0, STAT_NEW, 16'd0);
    add_row(1, KIND_CLEAR, 32'h1234_5678, 16'hABCD, 48'd5, 16'd5, 16'd5,
            1, 0, STAT_CLEARED, 16'd0);
    add_row(1, KIND_CHECK, 32'd0, 16'd0, 48'd0, 16'd0, 16'd0, 1, 1, STAT_NEW, 16'd1);
    add_row(1, KIND_CHECK, 32'd0, 16'd0, 48'd0, 16'd0, 16'hFFFF, 0, 0, STAT_NEW, 16'd0);
    // disabled with a filled table, then the table is still there
    add_row(0, KIND_CHECK, 32'h5555_5555, 16'hAAAA, 48'd9, 16'd0, 16'd0,
            1, 1, STAT_DISABLED, 16'd0);
    add_row(0, KIND_CLEAR, 32'd0, 16'd0, 48'd0, 16'd0, 16'd0, 1, 1, STAT_DISABLED, 16'd0);
    add_row(1, KIND_CHECK, 32'd0, 16'd0, 48'd500, 16'd0, 16'hFFFF, 0, 0, STAT_NEW, 16'd0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      if (row.en != en_shadow) begin
        drain();
        set_enable(row.en);
      end
      send_req(row.r, row.typed, row.exp);
    end

    // random phases: pool, disabled, fill to full, full table, no idling, disabled, mixed
    for (ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: begin set_enable(1'b1); n_items = 150; fill = 0; end
        1: begin set_enable(1'b0); n_items = 40;  fill = 0; end
        2: begin
          set_enable(1'b1);
          n_items = 110;
          fill = 1;
          send_req(random_req(1'b0), 0, none);
        end
        3: begin n_items = 60;  fill = 0; end
        4: begin idle_en = 1'b0; n_items = 150; fill = 0; end
        5: begin idle_en = 1'b1; set_enable(1'b0); n_items = 20; fill = 0; end
        default: begin set_enable(1'b1); n_items = 100; fill = 0; end
      endcase
      for (i = 0; i < n_items; i++) begin
        if (ph == 0 && i == 50) hold_req++;
        // a pause with nothing in flight, mid-phase
        if (ph == 6 && i == 50) drain();
        send_req(random_req(fill), 0, none);
      end
    end

    drain();
    if (err_cnt == 0 && decision_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
